// ===== rtl/rtwh_pkg.sv =====
// Package for the rolling Toeplitz window hash: constants, command codes and
// the GF(2) multiply-by-x step. No dependencies.
package rtwh_pkg;

   localparam int WINDOW_DEFAULT = 64;
   localparam int QUEUE_DEPTH = 4;
   localparam logic [63:0] POLY_LOW = 64'h1B;

   typedef enum logic [1:0] {
      CMD_TABLE_WRITE = 2'd0,
      CMD_DATA        = 2'd1,
      CMD_RESTART     = 2'd2
   } cmd_type;

   typedef enum logic {
      TABLE_INCOMING = 1'b0,
      TABLE_OUTGOING = 1'b1
   } table_type;

   typedef struct packed {
      logic [63:0] digest;
      logic        window_full;
   } result_type;

   function automatic logic [63:0] times_x(input logic [63:0] v);
      times_x = {v[62:0], 1'b0} ^ (v[63] ? POLY_LOW : 64'd0);
   endfunction

endpackage

// ===== rtl/rtwh_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered,
// read-first output. No dependencies.
module rtwh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/rolling_toeplitz_window_hash_top.sv =====
// Top level of the rolling Toeplitz window hash: pipeline around the two
// table memories and the window memory, and the result queue.
// Depends on rtwh_pkg and rtwh_ram.
//
// Usage: the req channel carries table writes, data bytes and restarts.
// A table write stores a 64-bit entry in the incoming or outgoing table.
// Each data byte produces one rsp item with the digest of the current
// window and a flag that is set once the window holds WINDOW bytes. A
// restart empties the window and clears the digest; the tables are kept.
// Neither a table write nor a restart produces an rsp item.
// Throughput is one item per cycle while req_stall is low. A data byte
// reads the incoming table and the window memory in the cycle it is
// accepted, the outgoing table in the next, and its digest passes the s1
// and s2 registers before it enters the result queue and sets rsp_valid.
// The digest register feeds back through multiply by x, reduce, XOR.
// When rsp_stall is held, results collect in a four-entry queue and
// req_stall rises once four data bytes are accepted and not yet taken.
// Reset clears the window, the digest and the queue; the
// table contents are undefined until written.
module rolling_toeplitz_window_hash_top #(
   parameter int WINDOW = rtwh_pkg::WINDOW_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic        req_table_select,
   input  logic [7:0]  req_table_index,
   input  logic [63:0] req_table_value,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_digest,
   output logic        rsp_window_full
);

   import rtwh_pkg::*;

   localparam int POS_W = $clog2(WINDOW);
   localparam int FILL_W = $clog2(WINDOW + 1);
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   logic              accept;
   logic              accept_data;
   logic              accept_restart;
   logic              write_incoming;
   logic              write_outgoing;
   logic              full_now;

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [FILL_W-1:0] fill_ff, fill_in;

   logic              s1_data_ff, s1_data_in;
   logic              s1_restart_ff, s1_restart_in;
   logic              s1_xor_out_ff, s1_xor_out_in;
   logic              s1_full_ff, s1_full_in;

   logic              s2_data_ff;
   logic              s2_restart_ff;
   logic              s2_xor_out_ff;
   logic              s2_full_ff;
   logic [63:0]       s2_in_entry_ff;

   logic [63:0]       in_entry;
   logic [63:0]       out_entry;
   logic [7:0]        old_byte;
   logic [63:0]       digest_ff, digest_in;
   logic [63:0]       new_digest;

   result_type        queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] q_count_ff, q_count_in;
   logic [QCNT_W-1:0] credit_ff, credit_in;
   logic              pop;
   result_type        head;

   assign req_stall = (credit_ff == QCNT_W'(QUEUE_DEPTH));
   assign accept = req_valid && !req_stall;
   assign accept_data = accept && (req_cmd == CMD_DATA);
   assign accept_restart = accept && (req_cmd == CMD_RESTART);
   assign write_incoming = accept && (req_cmd == CMD_TABLE_WRITE)
                           && (req_table_select == TABLE_INCOMING);
   assign write_outgoing = accept && (req_cmd == CMD_TABLE_WRITE)
                           && (req_table_select == TABLE_OUTGOING);
   assign full_now = (fill_ff == FILL_W'(WINDOW));

   rtwh_ram #(.WIDTH(64), .DEPTH(256)) u_incoming (
      .clock   (clock),
      .wr_en   (write_incoming),
      .wr_addr (req_table_index),
      .wr_data (req_table_value),
      .rd_addr (req_data_byte),
      .rd_data (in_entry)
   );

   rtwh_ram #(.WIDTH(8), .DEPTH(WINDOW)) u_window (
      .clock   (clock),
      .wr_en   (accept_data),
      .wr_addr (pos_ff),
      .wr_data (req_data_byte),
      .rd_addr (pos_ff),
      .rd_data (old_byte)
   );

   rtwh_ram #(.WIDTH(64), .DEPTH(256)) u_outgoing (
      .clock   (clock),
      .wr_en   (write_outgoing),
      .wr_addr (req_table_index),
      .wr_data (req_table_value),
      .rd_addr (old_byte),
      .rd_data (out_entry)
   );

   always_comb begin
      pos_in = pos_ff;
      fill_in = fill_ff;
      if (accept_restart) begin
         pos_in = '0;
         fill_in = '0;
      end else if (accept_data) begin
         pos_in = (pos_ff == POS_W'(WINDOW - 1)) ? '0 : pos_ff + POS_W'(1);
         if (!full_now) begin
            fill_in = fill_ff + FILL_W'(1);
         end
      end
      s1_data_in = accept_data;
      s1_restart_in = accept_restart;
      s1_xor_out_in = full_now;
      s1_full_in = full_now || (fill_ff == FILL_W'(WINDOW - 1));
   end

   assign new_digest = times_x(digest_ff) ^ s2_in_entry_ff
                       ^ (s2_xor_out_ff ? out_entry : 64'd0);

   always_comb begin
      digest_in = digest_ff;
      if (s2_restart_ff) begin
         digest_in = '0;
      end else if (s2_data_ff) begin
         digest_in = new_digest;
      end
   end

   assign rsp_valid = (q_count_ff != '0);
   assign pop = rsp_valid && !rsp_stall;
   assign head = queue_ff[rd_ptr_ff];
   assign rsp_digest = head.digest;
   assign rsp_window_full = head.window_full;

   always_comb begin
      wr_ptr_in = s2_data_ff ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      q_count_in = q_count_ff + QCNT_W'(s2_data_ff) - QCNT_W'(pop);
      credit_in = credit_ff + QCNT_W'(accept_data) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         fill_ff <= '0;
         s1_data_ff <= 1'b0;
         s1_restart_ff <= 1'b0;
         s2_data_ff <= 1'b0;
         s2_restart_ff <= 1'b0;
         digest_ff <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         q_count_ff <= '0;
         credit_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         fill_ff <= fill_in;
         s1_data_ff <= s1_data_in;
         s1_restart_ff <= s1_restart_in;
         s2_data_ff <= s1_data_ff;
         s2_restart_ff <= s1_restart_ff;
         digest_ff <= digest_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         q_count_ff <= q_count_in;
         credit_ff <= credit_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_xor_out_ff <= s1_xor_out_in;
      s1_full_ff <= s1_full_in;
      s2_xor_out_ff <= s1_xor_out_ff;
      s2_full_ff <= s1_full_ff;
      s2_in_entry_ff <= in_entry;
      if (s2_data_ff) begin
         queue_ff[wr_ptr_ff] <= '{digest: new_digest, window_full: s2_full_ff};
      end
   end

endmodule

// ===== bench/rolling_toeplitz_window_hash_top_test.sv =====
`timescale 1ns / 1ps
// Testbench for rolling_toeplitz_window_hash_top: loads both tables, then drives directed and
// random streams of table writes, data bytes and restarts while a digest tracker checks each
// result. Depends on rtwh_pkg and the block's RTL.
module rolling_toeplitz_window_hash_top_test;
   import rtwh_pkg::*;

   localparam int WINDOW_SIZE = WINDOW_DEFAULT;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int LONG_HOLD = 48;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int PHASE_ITEMS = 185;

   class digest_tracker;
      logic [63:0] incoming_entry [256];
      logic [63:0] outgoing_entry [256];
      logic [7:0]  window_content [WINDOW_SIZE];
      int unsigned position;
      int unsigned fill;
      logic [63:0] digest;
      result_type  digests_due[$];
      int          errors;

      function new();
         position = 0;
         fill = 0;
         digest = 64'd0;
         errors = 0;
      endfunction

      function void note_request(logic [1:0] cmd, logic sel, logic [7:0] idx,
                                 logic [63:0] value, logic [7:0] data);
         result_type due;
         case (cmd)
            CMD_TABLE_WRITE: begin
               if (sel == TABLE_INCOMING) incoming_entry[idx] = value;
               else outgoing_entry[idx] = value;
            end
            CMD_RESTART: begin
               position = 0;
               fill = 0;
               digest = 64'd0;
            end
            CMD_DATA: begin
               digest = {digest[62:0], 1'b0} ^ (digest[63] ? POLY_LOW : 64'd0)
                        ^ incoming_entry[data];
               if (fill == WINDOW_SIZE) digest ^= outgoing_entry[window_content[position]];
               else fill++;
               window_content[position] = data;
               position = (position + 1) % WINDOW_SIZE;
               due.digest = digest;
               due.window_full = (fill == WINDOW_SIZE);
               digests_due.push_back(due);
            end
            default: ;
         endcase
      endfunction

      function void check_digest(logic [63:0] got_digest, logic got_full);
         result_type due;
         if (digests_due.size() == 0) begin
            $display("%0t: result with none expected: digest %h full %b", $time, got_digest,
                     got_full);
            errors++;
            return;
         end
         due = digests_due.pop_front();
         if (due.digest !== got_digest) begin
            $display("%0t: digest expected %h, actual %h", $time, due.digest, got_digest);
            errors++;
         end
         if (due.window_full !== got_full) begin
            $display("%0t: window_full expected %b, actual %b", $time, due.window_full,
                     got_full);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_cmd;
   logic        req_table_select;
   logic [7:0]  req_table_index;
   logic [63:0] req_table_value;
   logic [7:0]  req_data_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [63:0] rsp_digest;
   logic        rsp_window_full;

   digest_tracker tracker;
   int            req_idle_pct;
   int            rsp_stall_pct;
   bit            long_hold_request;
   int            quiet_cycles;

   rolling_toeplitz_window_hash_top #(.WINDOW(WINDOW_SIZE)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_cmd(req_cmd),
      .req_table_select(req_table_select),
      .req_table_index(req_table_index),
      .req_table_value(req_table_value),
      .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_digest(rsp_digest),
      .rsp_window_full(rsp_window_full)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic logic [63:0] random_word();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [7:0] random_byte();
      return 8'($urandom_range(255));
   endfunction

   function automatic logic random_bit();
      return 1'($urandom_range(1));
   endfunction

   // Data bytes come from sixteen values that include both extremes, so only their table
   // entries need loading.
   function automatic logic [7:0] spread_byte(input logic [3:0] code);
      return {code[3], {3{code[2]}}, {3{code[1]}}, code[0]};
   endfunction

   task automatic offer(input logic [1:0] cmd, input logic sel, input logic [7:0] idx,
                        input logic [63:0] value, input logic [7:0] data);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_table_select <= sel;
      req_table_index <= idx;
      req_table_value <= value;
      req_data_byte <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.digests_due.size() != 0) @(posedge clock);
   endtask

   // Restarts, each followed by a run that is mostly long enough to fill and roll the window, with
   // table rewrites, ignored commands and stray restarts mixed in.
   task automatic stream_phase(input int goal);
      int         sent;
      int         run_length;
      int         step;
      int         pick;
      logic [7:0] last_byte;
      logic [7:0] data;
      sent = 0;
      last_byte = 8'd0;
      while (sent < goal) begin
         offer(CMD_RESTART, random_bit(), random_byte(), random_word(), random_byte());
         sent++;
         run_length = ($urandom_range(9) == 0) ? $urandom_range(1, 20)
                      : $urandom_range(WINDOW_SIZE + 1, 3 * WINDOW_SIZE);
         for (step = 0; step < run_length && sent < goal; step++) begin
            pick = $urandom_range(99);
            if (pick < 84) begin
               data = spread_byte(4'($urandom_range(15)));
               offer(CMD_DATA, random_bit(), random_byte(), random_word(), data);
               last_byte = data;
            end else if (pick < 93) begin
               offer(CMD_TABLE_WRITE, random_bit(), random_bit() ? last_byte : random_byte(),
                     random_word(), random_byte());
            end else if (pick < 97) begin
               offer(CMD_UNUSED, random_bit(), random_byte(), random_word(), random_byte());
            end else begin
               offer(CMD_RESTART, random_bit(), random_byte(), random_word(), random_byte());
            end
            sent++;
         end
      end
   endtask

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) tracker.check_digest(rsp_digest, rsp_window_full);
         if (req_valid && !req_stall)
            tracker.note_request(req_cmd, req_table_select, req_table_index, req_table_value,
                                 req_data_byte);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("rolling_toeplitz_window_hash_top test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int entry;
      tracker = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_cmd = CMD_RESTART;
      req_table_select = TABLE_INCOMING;
      req_table_index = 8'd0;
      req_table_value = 64'd0;
      req_data_byte = 8'd0;
      long_hold_request = 1'b0;
      quiet_cycles = 0;
      req_idle_pct = 18;
      rsp_stall_pct = 60;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Both table entries of every byte value that the stream uses are written before any
      // data byte reads them.
      for (entry = 0; entry < 16; entry++) begin
         offer(CMD_TABLE_WRITE, TABLE_INCOMING, spread_byte(4'(entry)), random_word(),
               random_byte());
         offer(CMD_TABLE_WRITE, TABLE_OUTGOING, spread_byte(4'(entry)), random_word(),
               random_byte());
      end

      offer(CMD_RESTART, TABLE_INCOMING, 8'h00, 64'd0, 8'h00);
      offer(CMD_DATA, TABLE_INCOMING, 8'h00, 64'd0, 8'h00);
      offer(CMD_DATA, TABLE_OUTGOING, 8'hFF, '1, 8'hFF);
      offer(CMD_TABLE_WRITE, TABLE_INCOMING, 8'h00, '1, 8'h00);
      offer(CMD_DATA, TABLE_INCOMING, 8'h00, 64'd0, 8'h00);
      offer(CMD_TABLE_WRITE, TABLE_OUTGOING, 8'hFF, 64'd0, 8'hFF);
      offer(CMD_TABLE_WRITE, TABLE_INCOMING, 8'hFF, 64'h8000_0000_0000_0000, 8'h00);
      offer(CMD_DATA, TABLE_INCOMING, 8'h00, 64'd0, 8'hFF);
      offer(CMD_DATA, TABLE_INCOMING, 8'h00, 64'd0, 8'hFF);
      offer(CMD_UNUSED, TABLE_OUTGOING, 8'hFF, '1, 8'hFF);
      offer(CMD_DATA, TABLE_INCOMING, 8'h00, 64'd0, 8'h80);
      offer(CMD_RESTART, TABLE_OUTGOING, 8'hFF, '1, 8'hFF);
      offer(CMD_DATA, TABLE_INCOMING, 8'h00, 64'd0, 8'hFF);
      offer(CMD_TABLE_WRITE, TABLE_OUTGOING, 8'h00, 64'd1, 8'h00);
      offer(CMD_DATA, TABLE_INCOMING, 8'h00, 64'd0, 8'h01);
      drain();

      stream_phase(PHASE_ITEMS);
      drain();
      req_idle_pct = 60;
      rsp_stall_pct = 18;
      stream_phase(PHASE_ITEMS);
      drain();
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      long_hold_request = 1'b1;
      stream_phase(PHASE_ITEMS);
      drain();

      repeat (10) @(posedge clock);
      if (tracker.errors == 0 && tracker.digests_due.size() == 0) begin
         $display("rolling_toeplitz_window_hash_top test passed");
      end else begin
         $display("rolling_toeplitz_window_hash_top test failed");
      end
      $finish;
   end
endmodule

// ===== rolling_toeplitz_window_hash_top.f =====
rtl/rtwh_pkg.sv
rtl/rtwh_ram.sv
rtl/rolling_toeplitz_window_hash_top.sv
bench/rolling_toeplitz_window_hash_top_test.sv
